[rtl/core/hmcd_pkg.sv]
// Package for the HTTP message completeness detector: beat types, phase codes, byte constants.
`default_nettype none
package hmcd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_beat_t;

  typedef struct packed {
    logic        headers_done;
    logic        message_complete;
    logic [31:0] msg_length;
    logic        length_overflow;
    logic        length_error;
  } out_beat_t;

  typedef enum logic [1:0] {
    PH_SEEK  = 2'd0,
    PH_BLANK = 2'd1,
    PH_DIGIT = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  localparam logic [3:0] NAME_LEN = 4'd15;
  localparam logic [2:0] END_LEN  = 3'd4;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_C     = 8'h63;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UZ    = 8'h5A;

  function automatic logic [7:0] name_char(input logic [3:0] pos);
    case (pos)
      4'd0:    name_char = 8'h63; // c
      4'd1:    name_char = 8'h6F; // o
      4'd2:    name_char = 8'h6E; // n
      4'd3:    name_char = 8'h74; // t
      4'd4:    name_char = 8'h65; // e
      4'd5:    name_char = 8'h6E; // n
      4'd6:    name_char = 8'h74; // t
      4'd7:    name_char = 8'h2D; // -
      4'd8:    name_char = 8'h6C; // l
      4'd9:    name_char = 8'h65; // e
      4'd10:   name_char = 8'h6E; // n
      4'd11:   name_char = 8'h67; // g
      4'd12:   name_char = 8'h74; // t
      4'd13:   name_char = 8'h68; // h
      4'd14:   name_char = 8'h3A; // :
      default: name_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] end_char(input logic [2:0] pos);
    case (pos)
      3'd0:    end_char = CHAR_CR;
      3'd1:    end_char = CHAR_LF;
      3'd2:    end_char = CHAR_CR;
      3'd3:    end_char = CHAR_LF;
      default: end_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= CHAR_UA && c <= CHAR_UZ) begin
      to_lower = c + 8'd32;
    end else begin
      to_lower = c;
    end
  endfunction

endpackage
`default_nettype wire

[rtl/core/hmcd_parse.sv]
// Per-byte parse state: header end matcher, length header matcher, digit accumulator, body counter.
`default_nettype none
module hmcd_parse #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire hmcd_pkg::in_beat_t beat_i,
  output hmcd_pkg::out_beat_t     result_o
);
  import hmcd_pkg::*;

  localparam int WideW = LENGTH_BITS + 4;
  localparam logic [LENGTH_BITS-1:0] LenMax = '1;

  logic [2:0]             end_pos_q, end_pos_d;
  logic [3:0]             name_pos_q, name_pos_d;
  phase_e                 phase_q, phase_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [LENGTH_BITS-1:0] body_q, body_d;
  logic                   hdr_q, hdr_d;
  logic                   ovf_q, ovf_d;
  logic                   err_q, err_d;

  logic [7:0]             b;
  logic [7:0]             lc;
  logic [LENGTH_BITS-1:0] len_base;
  logic [WideW-1:0]       wide;
  logic                   do_digit;
  logic [31:0]            len_out;

  assign b        = beat_i.data_byte;
  assign lc       = to_lower(b);
  assign len_base = beat_i.first_byte ? '0 : len_q;
  assign wide     = ({4'b0, len_base} << 3) + ({4'b0, len_base} << 1) + WideW'(b[3:0]);

  always_comb begin
    logic [2:0]             e_pos;
    logic [3:0]             n_pos;
    phase_e                 ph;
    logic [LENGTH_BITS-1:0] len;
    logic [LENGTH_BITS-1:0] body;
    logic                   hdr;
    logic                   ovf;
    logic                   err;
    e_pos = end_pos_q;
    n_pos = name_pos_q;
    ph    = phase_q;
    len   = len_q;
    body  = body_q;
    hdr   = hdr_q;
    ovf   = ovf_q;
    err   = err_q;
    do_digit = 1'b0;
    if (beat_i.first_byte) begin
      e_pos = '0;
      n_pos = '0;
      ph    = PH_SEEK;
      len   = '0;
      body  = '0;
      hdr   = 1'b0;
      ovf   = 1'b0;
      err   = 1'b0;
    end
    if (hdr) begin
      if (body != LenMax) begin
        body = body + 1'b1;
      end
    end else begin
      case (ph)
        PH_SEEK: begin
          if (n_pos < NAME_LEN && lc == name_char(n_pos)) begin
            n_pos = n_pos + 4'd1;
          end else begin
            n_pos = (lc == CHAR_C) ? 4'd1 : 4'd0;
          end
          if (n_pos >= NAME_LEN) begin
            ph = PH_BLANK;
          end
        end
        PH_BLANK: begin
          if (b == CHAR_SP || b == CHAR_TAB) begin
            ph = PH_BLANK;
          end else if (b == CHAR_MINUS) begin
            err = 1'b1;
            ph  = PH_DONE;
          end else if (b == CHAR_PLUS) begin
            ph = PH_DIGIT;
          end else begin
            ph = PH_DIGIT;
            do_digit = 1'b1;
          end
        end
        PH_DIGIT: begin
          do_digit = 1'b1;
        end
        default: begin
          ph = PH_DONE;
        end
      endcase
      if (do_digit) begin
        if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
          if (wide[WideW-1:LENGTH_BITS] != 4'd0) begin
            len = LenMax;
            ovf = 1'b1;
          end else begin
            len = wide[LENGTH_BITS-1:0];
          end
        end else begin
          ph = PH_DONE;
        end
      end
      if (e_pos < END_LEN && b == end_char(e_pos)) begin
        e_pos = e_pos + 3'd1;
      end else begin
        e_pos = (b == CHAR_CR) ? 3'd1 : 3'd0;
      end
      if (e_pos >= END_LEN) begin
        hdr  = 1'b1;
        body = '0;
      end
    end
    end_pos_d  = e_pos;
    name_pos_d = n_pos;
    phase_d    = ph;
    len_d      = len;
    body_d     = body;
    hdr_d      = hdr;
    ovf_d      = ovf;
    err_d      = err;
  end

  generate
    if (LENGTH_BITS > 32) begin : g_sat
      assign len_out = (|len_d[LENGTH_BITS-1:32]) ? 32'hFFFF_FFFF : len_d[31:0];
    end else begin : g_ext
      assign len_out = 32'(len_d);
    end
  endgenerate

  always_comb begin
    result_o.headers_done     = hdr_d;
    result_o.message_complete = hdr_d && (len_d == '0 || body_d >= len_d);
    result_o.msg_length       = len_out;
    result_o.length_overflow  = ovf_d;
    result_o.length_error     = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_pos_q  <= '0;
      name_pos_q <= '0;
      phase_q    <= PH_SEEK;
      len_q      <= '0;
      body_q     <= '0;
      hdr_q      <= 1'b0;
      ovf_q      <= 1'b0;
      err_q      <= 1'b0;
    end else if (accept_i) begin
      end_pos_q  <= end_pos_d;
      name_pos_q <= name_pos_d;
      phase_q    <= phase_d;
      len_q      <= len_d;
      body_q     <= body_d;
      hdr_q      <= hdr_d;
      ovf_q      <= ovf_d;
      err_q      <= err_d;
    end
  end

  a_hdr_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !beat_i.first_byte && hdr_q |-> result_o.headers_done)
    else $error("headers_done dropped without a new message");

  a_hdr_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_q == (end_pos_q == END_LEN))
    else $error("header end flag and matcher position disagree");

  a_body_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hdr_q |-> body_q == '0)
    else $error("body bytes counted before header end");

  a_name_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SEEK |-> name_pos_q < NAME_LEN)
    else $error("name matcher ran past pattern while seeking");

endmodule
`default_nettype wire

[rtl/core/hmcd_out_reg.sv]
// Result register with valid/stall handshake toward the receiver.
`default_nettype none
module hmcd_out_reg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire hmcd_pkg::out_beat_t result_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output hmcd_pkg::out_beat_t      out_beat_o
);
  import hmcd_pkg::*;

  logic      valid_q, valid_d;
  out_beat_t beat_q;
  logic      load;

  assign in_stall_o = valid_q && out_stall_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load ? 1'b1 : (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o)
    else $error("accepted beat produced no result");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_stall_i && !load |=> !out_valid_o)
    else $error("result repeated after it was taken");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("stalled result changed");

endmodule
`default_nettype wire

[rtl/core/http_message_completeness_detector_unit.sv]
// Top level of the HTTP message completeness detector (Content-Length framing).
//
// Input channel: one message byte per beat (in_beat_i.data_byte), with
// in_beat_i.first_byte set on the byte that opens a new message; that byte
// clears all parse state before it is parsed. Output channel: one result
// beat per input beat, in order, carrying headers_done, message_complete,
// msg_length (saturated to 32 bits), length_overflow and length_error.
// The result of a byte is registered: it is loaded into the result register
// when the byte is accepted and shows at the output right after that edge.
// Throughput is one byte per cycle while the receiver does not stall, set by the
// single parse update between the state registers and the result register.
// When the receiver stalls while a result is waiting, in_stall_o is raised
// in the same cycle and the waiting result holds; the stall clears as soon as
// the result is taken, and a new byte may be accepted in that same cycle.
// Reset clears the parse state and empties the result register.
`default_nettype none
module http_message_completeness_detector_unit #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire hmcd_pkg::in_beat_t  in_beat_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output hmcd_pkg::out_beat_t      out_beat_o
);
  import hmcd_pkg::*;

  out_beat_t result;
  logic      accept;

  assign accept = in_valid_i && !in_stall_o;

  hmcd_parse #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .beat_i   (in_beat_i),
    .result_o (result)
  );

  hmcd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .result_i    (result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
`default_nettype wire
